>>> hw/rtl/e2q_pkg.sv
// Shared widths, CORDIC constants and beat types for the Euler-to-quaternion block.
`default_nettype none

package e2q_pkg;

   localparam int unsigned ANGLE_BITS      = 16;
   localparam int unsigned FRAC_BITS       = 14;
   localparam int unsigned QUAT_BITS       = FRAC_BITS + 2;

   // datapath word: signed Q1.30 with headroom
   localparam int unsigned ACC_BITS        = 32;
   localparam int unsigned Q_SHIFT         = 30;
   localparam int unsigned HALF_SHIFT      = ACC_BITS - 1 - ANGLE_BITS;
   localparam int unsigned ROUND_SHIFT     = Q_SHIFT - FRAC_BITS;

   localparam int unsigned LANES           = 3;
   localparam int unsigned CORDIC_STEPS    = 28;
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

   localparam logic signed [ACC_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

   // atan(2^-i) as a binary angle, 2^32 per turn
   localparam logic signed [ACC_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
      32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
      32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
      32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D,
      32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518,
      32'sh0000_028C, 32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051,
      32'sh0000_0029, 32'sh0000_0014, 32'sh0000_000A, 32'sh0000_0005
   };

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_x;
      logic [ANGLE_BITS-1:0] angle_y;
      logic [ANGLE_BITS-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] quat_w;
      logic signed [QUAT_BITS-1:0] quat_x;
      logic signed [QUAT_BITS-1:0] quat_y;
      logic signed [QUAT_BITS-1:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] cos_x;
      logic signed [ACC_BITS-1:0] sin_x;
      logic signed [ACC_BITS-1:0] cos_y;
      logic signed [ACC_BITS-1:0] sin_y;
      logic signed [ACC_BITS-1:0] cos_z;
      logic signed [ACC_BITS-1:0] sin_z;
   } trig_type;

endpackage

`default_nettype wire

>>> hw/rtl/e2q_cordic.sv
// Pipelined three-lane CORDIC giving cosine and sine of each half angle in Q1.30.
`default_nettype none

module e2q_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  e2q_pkg::req_type   in_angles,
   output logic               out_valid,
   output e2q_pkg::trig_type  out_trig
);

   localparam int unsigned W   = e2q_pkg::ACC_BITS;
   localparam int unsigned AB  = e2q_pkg::ANGLE_BITS;
   localparam int unsigned NL  = e2q_pkg::LANES;
   localparam int unsigned NS  = e2q_pkg::CORDIC_STAGES;
   localparam int unsigned SPS = e2q_pkg::STEPS_PER_STAGE;

   logic [AB-1:0]         angle  [NL];
   logic signed [W-1:0]   z_init [NL];

   logic signed [W-1:0]   x_src [NS][NL];
   logic signed [W-1:0]   y_src [NS][NL];
   logic signed [W-1:0]   z_src [NS][NL];
   logic signed [W-1:0]   x_in  [NS][NL];
   logic signed [W-1:0]   y_in  [NS][NL];
   logic signed [W-1:0]   z_in  [NS][NL];
   logic signed [W-1:0]   x_ff  [NS][NL];
   logic signed [W-1:0]   y_ff  [NS][NL];
   logic signed [W-1:0]   z_ff  [NS][NL];
   logic [NL-1:0]         flip_in [NS];
   logic [NL-1:0]         flip_ff [NS];
   logic [NS-1:0]         vld_ff;

   e2q_pkg::trig_type     trig_in;
   e2q_pkg::trig_type     trig_ff;
   logic                  out_vld_ff;

   assign angle[0] = in_angles.angle_x;
   assign angle[1] = in_angles.angle_y;
   assign angle[2] = in_angles.angle_z;

   // Half angle as a signed binary angle: the top angle bit both folds the
   // angle into [-quarter, +quarter) and marks the negated result.
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         z_init[l] = {angle[l][AB-1], angle[l], {e2q_pkg::HALF_SHIFT{1'b0}}};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_head
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               x_src[0][l]   = e2q_pkg::CORDIC_GAIN;
               y_src[0][l]   = '0;
               z_src[0][l]   = z_init[l];
               flip_in[0][l] = angle[l][AB-1];
            end
         end
      end else begin : g_body
         always_comb begin
            for (int l = 0; l < NL; l++) begin
               x_src[s][l] = x_ff[s-1][l];
               y_src[s][l] = y_ff[s-1][l];
               z_src[s][l] = z_ff[s-1][l];
            end
            flip_in[s] = flip_ff[s-1];
         end
      end

      always_comb begin : micro_rot
         logic signed [W-1:0] xv;
         logic signed [W-1:0] yv;
         logic signed [W-1:0] zv;
         logic signed [W-1:0] dx;
         logic signed [W-1:0] dy;
         for (int l = 0; l < NL; l++) begin
            xv = x_src[s][l];
            yv = y_src[s][l];
            zv = z_src[s][l];
            for (int k = 0; k < SPS; k++) begin
               dx = yv >>> (s * SPS + k);
               dy = xv >>> (s * SPS + k);
               if (!zv[W-1]) begin
                  xv = xv - dx;
                  yv = yv + dy;
                  zv = zv - e2q_pkg::ATAN_TABLE[s * SPS + k];
               end else begin
                  xv = xv + dx;
                  yv = yv - dy;
                  zv = zv + e2q_pkg::ATAN_TABLE[s * SPS + k];
               end
            end
            x_in[s][l] = xv;
            y_in[s][l] = yv;
            z_in[s][l] = zv;
         end
      end
   end

   // undo the half-turn fold
   always_comb begin
      trig_in.cos_x = flip_ff[NS-1][0] ? -x_ff[NS-1][0] : x_ff[NS-1][0];
      trig_in.sin_x = flip_ff[NS-1][0] ? -y_ff[NS-1][0] : y_ff[NS-1][0];
      trig_in.cos_y = flip_ff[NS-1][1] ? -x_ff[NS-1][1] : x_ff[NS-1][1];
      trig_in.sin_y = flip_ff[NS-1][1] ? -y_ff[NS-1][1] : y_ff[NS-1][1];
      trig_in.cos_z = flip_ff[NS-1][2] ? -x_ff[NS-1][2] : x_ff[NS-1][2];
      trig_in.sin_z = flip_ff[NS-1][2] ? -y_ff[NS-1][2] : y_ff[NS-1][2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[NS-2:0], in_valid};
         out_vld_ff <= vld_ff[NS-1];
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      trig_ff <= trig_in;
   end

   assign out_valid = out_vld_ff;
   assign out_trig  = trig_ff;

endmodule

`default_nettype wire

>>> hw/rtl/euler_to_quaternion.sv
// Top level: Euler angles (x, y, z order) to a saturated unit quaternion.
`default_nettype none

// Usage
//   Input: drive req_data with the three binary angles (a full turn is 2^16)
//   and raise start; the beat is taken at any rising edge where start is high
//   and busy is low. busy is high only while reset is applied, so one beat
//   can be taken on every clock.
//   Output: every beat taken yields exactly one result beat, shown on
//   rsp_data for one cycle with rsp_strobe high; the receiver takes it at the
//   edge that ends that cycle and has no way to hold it off. Results leave in
//   the order their beats entered.
//   Stages: a start beat passes through 14 CORDIC stages of two
//   micro-rotations each, one stage for the half-turn fold, one for the pair
//   products, one for the triple products, one for the sum and one for
//   rounding and saturation.
//   Throughput: one beat per clock, sustained; the per-stage micro-rotations
//   and the 32x32 multipliers set the clock period.
//   Reset: synchronous; it empties the pipeline (all valid bits cleared) and
//   drops any beat still in flight. There is no other state.
module euler_to_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  e2q_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output e2q_pkg::rsp_type  rsp_data
);

   localparam int unsigned W    = e2q_pkg::ACC_BITS;
   localparam int unsigned QB   = e2q_pkg::QUAT_BITS;
   localparam int unsigned NQ   = 4;
   localparam int unsigned LATENCY = e2q_pkg::CORDIC_STAGES + 5;

   // component slots
   localparam int unsigned Q_W = 0;
   localparam int unsigned Q_X = 1;
   localparam int unsigned Q_Y = 2;
   localparam int unsigned Q_Z = 3;

   localparam logic signed [W+1:0] ROUND_BIAS = (W+2)'(2 ** (e2q_pkg::ROUND_SHIFT - 1));
   localparam logic signed [W+1:0] SAT_LIMIT  = (W+2)'(2 ** e2q_pkg::FRAC_BITS);
   localparam logic signed [QB-1:0] QUAT_LIMIT = QB'(2 ** e2q_pkg::FRAC_BITS);
   localparam logic signed [W-1:0]  TRIG_LIMIT = W'(2 ** e2q_pkg::Q_SHIFT + 256);

   // Q1.30 product, floor
   function automatic logic signed [W-1:0] mul_q30(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      p = a * b;
      return p[e2q_pkg::Q_SHIFT+W-1:e2q_pkg::Q_SHIFT];
   endfunction

   // round half up to FRAC_BITS, clamp to plus or minus one
   function automatic logic signed [QB-1:0] round_sat(input logic signed [W:0] v);
      logic signed [W+1:0] r;
      r = ((W+2)'(v) + ROUND_BIAS) >>> e2q_pkg::ROUND_SHIFT;
      if (r > SAT_LIMIT) begin
         return QB'(SAT_LIMIT);
      end else if (r < -SAT_LIMIT) begin
         return QB'(-SAT_LIMIT);
      end
      return QB'(r);
   endfunction

   function automatic logic in_unit(input logic signed [W-1:0] v);
      return (v <= TRIG_LIMIT) && (v >= -TRIG_LIMIT);
   endfunction

   logic                 accept;
   logic                 trig_vld;
   e2q_pkg::trig_type    trig;

   // pair products and the z terms carried alongside
   logic signed [W-1:0]  cc_in, ss_in, sc_in, cs_in;
   logic signed [W-1:0]  cc_ff, ss_ff, sc_ff, cs_ff, cz_ff, sz_ff;
   logic                 pair_vld_ff;

   logic signed [W-1:0]  term_a_in [NQ];
   logic signed [W-1:0]  term_b_in [NQ];
   logic signed [W-1:0]  term_a_ff [NQ];
   logic signed [W-1:0]  term_b_ff [NQ];
   logic                 term_vld_ff;

   logic signed [W:0]    sum_in [NQ];
   logic signed [W:0]    sum_ff [NQ];
   logic                 sum_vld_ff;

   e2q_pkg::rsp_type     rsp_in;
   e2q_pkg::rsp_type     rsp_ff;
   logic                 strobe_ff;

   // the pipeline never backs up; hold off only while reset clears it
   assign busy   = reset;
   assign accept = start && !busy;

   e2q_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_angles (req_data),
      .out_valid (trig_vld),
      .out_trig  (trig)
   );

   // x and y lanes first: four pair products
   always_comb begin
      cc_in = mul_q30(trig.cos_x, trig.cos_y);
      ss_in = mul_q30(trig.sin_x, trig.sin_y);
      sc_in = mul_q30(trig.sin_x, trig.cos_y);
      cs_in = mul_q30(trig.cos_x, trig.sin_y);
   end

   // then fold in the z lane: two terms per component
   always_comb begin
      term_a_in[Q_W] = mul_q30(cc_ff, cz_ff);
      term_b_in[Q_W] = mul_q30(ss_ff, sz_ff);
      term_a_in[Q_X] = mul_q30(sc_ff, cz_ff);
      term_b_in[Q_X] = mul_q30(cs_ff, sz_ff);
      term_a_in[Q_Y] = mul_q30(cs_ff, cz_ff);
      term_b_in[Q_Y] = mul_q30(sc_ff, sz_ff);
      term_a_in[Q_Z] = mul_q30(cc_ff, sz_ff);
      term_b_in[Q_Z] = mul_q30(ss_ff, cz_ff);
   end

   // w and y add their terms, x and z subtract
   always_comb begin
      sum_in[Q_W] = (W+1)'(term_a_ff[Q_W]) + (W+1)'(term_b_ff[Q_W]);
      sum_in[Q_X] = (W+1)'(term_a_ff[Q_X]) - (W+1)'(term_b_ff[Q_X]);
      sum_in[Q_Y] = (W+1)'(term_a_ff[Q_Y]) + (W+1)'(term_b_ff[Q_Y]);
      sum_in[Q_Z] = (W+1)'(term_a_ff[Q_Z]) - (W+1)'(term_b_ff[Q_Z]);
   end

   always_comb begin
      rsp_in.quat_w = round_sat(sum_ff[Q_W]);
      rsp_in.quat_x = round_sat(sum_ff[Q_X]);
      rsp_in.quat_y = round_sat(sum_ff[Q_Y]);
      rsp_in.quat_z = round_sat(sum_ff[Q_Z]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_vld_ff <= 1'b0;
         term_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         pair_vld_ff <= trig_vld;
         term_vld_ff <= pair_vld_ff;
         sum_vld_ff  <= term_vld_ff;
         strobe_ff   <= sum_vld_ff;
      end
      cc_ff     <= cc_in;
      ss_ff     <= ss_in;
      sc_ff     <= sc_in;
      cs_ff     <= cs_in;
      cz_ff     <= trig.cos_z;
      sz_ff     <= trig.sin_z;
      term_a_ff <= term_a_in;
      term_b_ff <= term_b_in;
      sum_ff    <= sum_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // every result beat goes back to an accepted start beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result beat without a matching start beat");

   // each CORDIC output must stay within plus or minus one, within rounding slack
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      trig_vld |-> (in_unit(trig.cos_x) && in_unit(trig.sin_x) &&
                    in_unit(trig.cos_y) && in_unit(trig.sin_y) &&
                    in_unit(trig.cos_z) && in_unit(trig.sin_z)))
      else $error("CORDIC output outside the unit range");

   // saturation keeps every component within plus or minus one
   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.quat_w <= QUAT_LIMIT && rsp_data.quat_w >= -QUAT_LIMIT &&
                      rsp_data.quat_x <= QUAT_LIMIT && rsp_data.quat_x >= -QUAT_LIMIT &&
                      rsp_data.quat_y <= QUAT_LIMIT && rsp_data.quat_y >= -QUAT_LIMIT &&
                      rsp_data.quat_z <= QUAT_LIMIT && rsp_data.quat_z >= -QUAT_LIMIT))
      else $error("quaternion component beyond saturation limit");

endmodule

`default_nettype wire

>>> sim/euler_to_quaternion_test.sv
// Self-checking bench for the Euler-angle to quaternion pipeline: directed table, then random beats.
`timescale 1ns / 100ps

module euler_to_quaternion_test;
   import e2q_pkg::*;

   localparam int RANDOM_BEATS = 1750;
   localparam int PIPE_LATENCY = 19;    // start beat to result strobe, as LATENCY in the block
   localparam int MAX_GAP      = 14;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 100;

   // atan(2^-i) as a binary angle, 2^32 per turn; first entry sits at the top
   localparam logic [28*32-1:0] ATAN_BAM = {
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005
   };
   localparam longint TRIG_GAIN   = 652032874;   // CORDIC gain compensation in Q1.30
   localparam longint QUARTER_BAM = 64'sd1073741824;
   localparam longint HALF_BAM    = 64'sd2147483648;
   localparam longint Q14_ONE     = 16384;

   // one row of the directed table; pinned rows carry a hand-read quaternion
   typedef struct packed {
      req_type angles;
      logic    pinned;
      rsp_type quat;
   } pose_row_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // expectation that travels with req_data, taken by the monitor on acceptance
   rsp_type      req_quat = '0;
   rsp_type      quats_due[$];
   pose_row_type pose_table[$];
   bit           burst_mode = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;

   euler_to_quaternion i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a correct run finishes in a small fraction of this.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, quats_due.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor: half-angle cosine and sine by a 28-step CORDIC in Q1.30,
   // triple products with floor at each step, round to Q1.14, saturate.
   // ------------------------------------------------------------------

   function automatic void half_turn_trig(input logic [ANGLE_BITS-1:0] angle,
                                          output longint cos_q30, output longint sin_q30);
      longint theta, x, y, z, dx, dy, step;
      bit     fold;
      // halve the angle by widening to a 2^32-per-turn binary angle
      theta = longint'(angle) << 15;
      // fold the second quarter back into CORDIC range, negate at the end
      fold = (theta >= QUARTER_BAM);
      if (fold) theta -= HALF_BAM;
      x = TRIG_GAIN;
      y = 0;
      z = theta;
      for (int i = 0; i < 28; i++) begin
         step = longint'(ATAN_BAM[(27-i)*32 +: 32]);
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= step;
         end else begin
            x += dx;
            y -= dy;
            z += step;
         end
      end
      cos_q30 = fold ? -x : x;
      sin_q30 = fold ? -y : y;
   endfunction

   function automatic longint triple_q30(input longint a, input longint b, input longint c);
      longint p;
      p = (a * b) >>> 30;
      return (p * c) >>> 30;
   endfunction

   function automatic logic signed [QUAT_BITS-1:0] round_q14(input longint v);
      longint r;
      // add half an output LSB, floor, then clamp to plus or minus one
      r = (v + 64'sd32768) >>> 16;
      if (r > Q14_ONE) r = Q14_ONE;
      if (r < -Q14_ONE) r = -Q14_ONE;
      return r[QUAT_BITS-1:0];
   endfunction

   function automatic rsp_type predict_quat(input req_type angles);
      longint  cx, sx, cy, sy, cz, sz;
      rsp_type q;
      half_turn_trig(angles.angle_x, cx, sx);
      half_turn_trig(angles.angle_y, cy, sy);
      half_turn_trig(angles.angle_z, cz, sz);
      q.quat_w = round_q14(triple_q30(cx, cy, cz) + triple_q30(sx, sy, sz));
      q.quat_x = round_q14(triple_q30(sx, cy, cz) - triple_q30(cx, sy, sz));
      q.quat_y = round_q14(triple_q30(cx, sy, cz) + triple_q30(sx, cy, sz));
      q.quat_z = round_q14(triple_q30(cx, cy, sz) - triple_q30(sx, sy, cz));
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic signed [QUAT_BITS-1:0] got,
                                  input logic signed [QUAT_BITS-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch %s at cycle %0d: got %0d, want %0d", what, cycle_count, got, want);
   endtask

   // Queue the expectation on every accepted beat, then compare any result beat.
   // Both look at values from before the edge, so process order does not matter.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy)
         quats_due.push_back(req_quat);
      if (!reset && rsp_strobe) begin
         if (quats_due.size() == 0) begin
            report_mismatch("result beat with nothing due", rsp_data.quat_w, '0);
         end else begin
            want = quats_due.pop_front();
            if (rsp_data.quat_w !== want.quat_w)
               report_mismatch("quat_w", rsp_data.quat_w, want.quat_w);
            if (rsp_data.quat_x !== want.quat_x)
               report_mismatch("quat_x", rsp_data.quat_x, want.quat_x);
            if (rsp_data.quat_y !== want.quat_y)
               report_mismatch("quat_y", rsp_data.quat_y, want.quat_y);
            if (rsp_data.quat_z !== want.quat_z)
               report_mismatch("quat_z", rsp_data.quat_z, want.quat_z);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic add_pose(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                           input logic pinned, input int w = 0, input int x = 0,
                           input int y = 0, input int z = 0);
      pose_row_type row;
      row.angles.angle_x = ax;
      row.angles.angle_y = ay;
      row.angles.angle_z = az;
      row.pinned         = pinned;
      row.quat.quat_w    = w[QUAT_BITS-1:0];
      row.quat.quat_x    = x[QUAT_BITS-1:0];
      row.quat.quat_y    = y[QUAT_BITS-1:0];
      row.quat.quat_z    = z[QUAT_BITS-1:0];
      pose_table.push_back(row);
   endtask

   task automatic build_pose_table();
      // identity, and a half turn about each axis; these hit the saturation clamp
      add_pose(16'h0000, 16'h0000, 16'h0000, 1'b1, 16384, 0, 0, 0);
      add_pose(16'h8000, 16'h0000, 16'h0000, 1'b1, 0, 16384, 0, 0);
      add_pose(16'h0000, 16'h8000, 16'h0000, 1'b1, 0, 0, 16384, 0);
      add_pose(16'h0000, 16'h0000, 16'h8000, 1'b1, 0, 0, 0, 16384);
      // half turn about all three axes lands back on the scalar axis
      add_pose(16'h8000, 16'h8000, 16'h8000, 1'b1, 16384, 0, 0, 0);
      // the rest go through the predictor
      add_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_pose(16'h4000, 16'h0000, 16'h0000, 1'b0);
      add_pose(16'h0000, 16'h4000, 16'h0000, 1'b0);
      add_pose(16'h0000, 16'h0000, 16'h4000, 1'b0);
      add_pose(16'hC000, 16'h4000, 16'hC000, 1'b0);
      add_pose(16'h0001, 16'h0001, 16'h0001, 1'b0);
      add_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);   // just below the fold
      add_pose(16'h8001, 16'h8001, 16'h8001, 1'b0);   // just past the fold
      add_pose(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
      add_pose(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
      add_pose(16'h1234, 16'h89AB, 16'hFEDC, 1'b0);
      add_pose(16'h00FF, 16'hFF00, 16'h0F0F, 1'b0);
      add_pose(16'h8000, 16'h4000, 16'hC000, 1'b0);
      add_pose(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      add_pose(16'hC001, 16'h3FFF, 16'hBFFF, 1'b0);
   endtask

   // Mostly uniform angles, with a share of corners and near-fold or near-wrap values.
   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      case ($urandom_range(9, 0))
         7: begin
            case ($urandom_range(7, 0))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h4000;
               3: return 16'h8000;
               4: return 16'hC000;
               5: return 16'h7FFF;
               6: return 16'h3FFF;
               default: return 16'hBFFF;
            endcase
         end
         8: return 16'h7FF0 + 16'($urandom_range(31, 0));
         9: return 16'($urandom_range(15, 0)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_pose();
      req_type a;
      a.angle_x = pick_angle();
      a.angle_y = pick_angle();
      a.angle_z = pick_angle();
      return a;
   endfunction

   // Present one beat, hold it until taken, then idle for a drawn gap unless in burst mode.
   task automatic drive_beat(input req_type angles, input rsp_type quat);
      int gap;
      req_data <= angles;
      req_quat <= quat;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = burst_mode ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold off until every outstanding result has come back.
   task automatic settle_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (quats_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_type angles;
      build_pose_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, with idle gaps
      foreach (pose_table[k])
         drive_beat(pose_table[k].angles,
                    pose_table[k].pinned ? pose_table[k].quat
                                         : predict_quat(pose_table[k].angles));
      settle_pipeline();

      // random part; back-to-back stretches alternate with gappy ones
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) burst_mode = ($urandom_range(2, 0) == 0);
         if (n == RANDOM_BEATS / 2 || $urandom_range(199, 0) == 0) settle_pipeline();
         angles = random_pose();
         drive_beat(angles, predict_quat(angles));
      end

      // drain, then leave room for any stray result beat
      settle_pipeline();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && quats_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
